@@ rtl/target_follow_velocity_controller_core_assert.svh @@
// Assertion macros for the follow controller core.
`ifndef TARGET_FOLLOW_VELOCITY_CONTROLLER_CORE_ASSERT_SVH
`define TARGET_FOLLOW_VELOCITY_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TFVC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TFVC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define TFVC_ASSERT(lbl, prop, msg)
`define TFVC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/tfvc_pkg.sv @@
`default_nettype none
package tfvc_pkg;
	localparam int unsigned REG_W = 15;
	localparam int unsigned POS_W = 16;
	localparam int unsigned VEL_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CORDIC_STEPS = 16;
	localparam int unsigned ANG_W = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STOP_DIST = 3'd0,
		REG_CAM_OFFSET = 3'd1,
		REG_SPEED_GAIN = 3'd2,
		REG_HEAD_GAIN = 3'd3,
		REG_DIST_GAIN = 3'd4,
		REG_MAX_LINEAR = 3'd5,
		REG_MAX_ANGULAR = 3'd6
	} reg_idx_t;

	localparam logic [REG_W-1:0] RST_STOP_DIST = 15'd2048;
	localparam logic [REG_W-1:0] RST_CAM_OFFSET = 15'd0;
	localparam logic [REG_W-1:0] RST_SPEED_GAIN = 15'd1065;
	localparam logic [REG_W-1:0] RST_HEAD_GAIN = 15'd1229;
	localparam logic [REG_W-1:0] RST_DIST_GAIN = 15'd1229;
	localparam logic [REG_W-1:0] RST_MAX_LINEAR = 15'd1638;
	localparam logic [REG_W-1:0] RST_MAX_ANGULAR = 15'd3277;

	localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 19'sd102944;

	// atan(2^-i) in Q.16 radians
	function automatic logic signed [ANG_W-1:0] atan_q16(input logic [3:0] i);
		logic signed [ANG_W-1:0] r;
		case (i)
			4'd0: r = 19'sd51472;
			4'd1: r = 19'sd30386;
			4'd2: r = 19'sd16055;
			4'd3: r = 19'sd8150;
			4'd4: r = 19'sd4091;
			4'd5: r = 19'sd2047;
			4'd6: r = 19'sd1024;
			4'd7: r = 19'sd512;
			4'd8: r = 19'sd256;
			4'd9: r = 19'sd128;
			4'd10: r = 19'sd64;
			4'd11: r = 19'sd32;
			4'd12: r = 19'sd16;
			4'd13: r = 19'sd8;
			4'd14: r = 19'sd4;
			default: r = 19'sd2;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/target_follow_velocity_controller_core.sv @@
// Follow controller core: turns a target pose (x_pos, z_pos, signed Q4.12 m)
// into a clamped velocity command (linear_vel, angular_vel) plus a stopped flag.
// Input and output channels are valid/ready; one result item per pose item.
// Throughput is one item per cycle while out_ready stays high, over 21 stages:
// squares, a setup stage, 16 shared square-root/CORDIC steps (one bit of root
// and one rotation per stage), an error stage, a multiplier stage and a
// round/clamp stage each hold one item.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse: with out_ready low the pipe keeps taking items until every
// stage is full, and only then in_ready drops. Nothing is lost or repeated.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index (0 stop
// distance, 1 camera offset, 2 speed gain, 3 heading gain, 4 distance gain,
// 5 max linear, 6 max angular); other indexes are ignored. Write only while
// the pipe is empty.
// Reset empties the pipe and loads the default register values.
`default_nettype none
module target_follow_velocity_controller_core
	import tfvc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [POS_W-1:0] x_pos,
	input wire logic signed [POS_W-1:0] z_pos,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [VEL_W-1:0] linear_vel,
	output logic signed [VEL_W-1:0] angular_vel,
	output logic stopped,
	input wire logic cfg_wr_en,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [REG_W-1:0] cfg_wdata
);
	localparam int unsigned NS = 21;
	localparam int unsigned IT0 = 2;

	logic [REG_W-1:0] stop_q, cam_q, sg_q, hg_q, dg_q, maxl_q, maxa_q;
	logic [2*REG_W-1:0] stop_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= RST_STOP_DIST;
			cam_q <= RST_CAM_OFFSET;
			sg_q <= RST_SPEED_GAIN;
			hg_q <= RST_HEAD_GAIN;
			dg_q <= RST_DIST_GAIN;
			maxl_q <= RST_MAX_LINEAR;
			maxa_q <= RST_MAX_ANGULAR;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_STOP_DIST: stop_q <= cfg_wdata;
				REG_CAM_OFFSET: cam_q <= cfg_wdata;
				REG_SPEED_GAIN: sg_q <= cfg_wdata;
				REG_HEAD_GAIN: hg_q <= cfg_wdata;
				REG_DIST_GAIN: dg_q <= cfg_wdata;
				REG_MAX_LINEAR: maxl_q <= cfg_wdata;
				REG_MAX_ANGULAR: maxa_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Square of the stop distance, settled before any item reaches the compare
	always_ff @(posedge clk) begin
		stop_sq_q <= stop_q * stop_q;
	end

	// Valid bits and per-stage advance
	logic [NS:1] v_s;
	logic [NS+1:1] adv;

	always_comb begin
		adv[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			adv[k] = !v_s[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (adv[1]) begin
				v_s[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (adv[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	assign in_ready = adv[1];
	assign out_valid = v_s[NS];

	// Stage 1: squares
	logic [2*POS_W-2:0] xsq_s1, zsq_s1;
	logic signed [POS_W-1:0] x_s1, z_s1;
	logic signed [2*POS_W-1:0] xprod, zprod;

	assign xprod = x_pos * x_pos;
	assign zprod = z_pos * z_pos;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			x_s1 <= x_pos;
			z_s1 <= z_pos;
			xsq_s1 <= xprod[2*POS_W-2:0];
			zsq_s1 <= zprod[2*POS_W-2:0];
		end
	end

	// Stage 2 and the 16 iteration stages share index arrays: index 0 is stage 2
	logic [31:0] rem_s [0:CORDIC_STEPS];
	logic [31:0] res_s [0:CORDIC_STEPS];
	logic signed [31:0] a_s [0:CORDIC_STEPS];
	logic signed [31:0] b_s [0:CORDIC_STEPS];
	logic signed [ANG_W-1:0] ang_s [0:CORDIC_STEPS];
	logic [CORDIC_STEPS:0] stp_s, zz_s, xp_s, xn_s;

	logic [31:0] sum2;
	logic signed [31:0] za, xb;
	assign sum2 = {1'b0, xsq_s1} + {1'b0, zsq_s1};
	assign za = z_s1[POS_W-1] ? -(32'(z_s1) <<< 14) : (32'(z_s1) <<< 14);
	assign xb = z_s1[POS_W-1] ? -(32'(x_s1) <<< 14) : (32'(x_s1) <<< 14);

	always_ff @(posedge clk) begin
		if (adv[IT0]) begin
			rem_s[0] <= sum2;
			res_s[0] <= '0;
			a_s[0] <= za;
			b_s[0] <= xb;
			ang_s[0] <= '0;
			stp_s[0] <= sum2 <= {2'b00, stop_sq_q};
			zz_s[0] <= z_s1 == '0;
			xp_s[0] <= !x_s1[POS_W-1] && x_s1 != '0;
			xn_s[0] <= x_s1[POS_W-1];
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
		localparam logic [31:0] BIT = 32'd1 << (30 - 2*k);
		logic [31:0] trial;
		logic take;
		assign trial = res_s[k] + BIT;
		assign take = rem_s[k] >= trial;

		always_ff @(posedge clk) begin
			if (adv[IT0+k+1]) begin
				rem_s[k+1] <= take ? rem_s[k] - trial : rem_s[k];
				res_s[k+1] <= take ? (res_s[k] >> 1) + BIT : res_s[k] >> 1;
				if (!b_s[k][31]) begin
					a_s[k+1] <= a_s[k] + (b_s[k] >>> k);
					b_s[k+1] <= b_s[k] - (a_s[k] >>> k);
					ang_s[k+1] <= ang_s[k] + atan_q16(4'(k));
				end else begin
					a_s[k+1] <= a_s[k] - (b_s[k] >>> k);
					b_s[k+1] <= b_s[k] + (a_s[k] >>> k);
					ang_s[k+1] <= ang_s[k] - atan_q16(4'(k));
				end
				stp_s[k+1] <= stp_s[k];
				zz_s[k+1] <= zz_s[k];
				xp_s[k+1] <= xp_s[k];
				xn_s[k+1] <= xn_s[k];
			end
		end
	end

	// Stage 19: distance error in Q7.12 and bearing in Q3.12
	localparam int unsigned S_ERR = IT0 + CORDIC_STEPS + 1;
	logic signed [18:0] err_s19;
	logic signed [14:0] th_s19;
	logic stp_s19;
	logic signed [ANG_W-1:0] ang_f, ang_r;
	localparam int unsigned L = CORDIC_STEPS;

	always_comb begin
		if (zz_s[L]) begin
			ang_f = xp_s[L] ? HALF_PI_Q16 : (xn_s[L] ? -HALF_PI_Q16 : '0);
		end else begin
			ang_f = ang_s[L];
		end
		ang_r = ang_f + 19'sd8;
	end

	always_ff @(posedge clk) begin
		if (adv[S_ERR]) begin
			err_s19 <= $signed({2'b00, res_s[L][16:0]})
				- $signed({4'b0000, stop_q}) - $signed({4'b0000, cam_q});
			th_s19 <= 15'(ang_r >>> 4);
			stp_s19 <= stp_s[L];
		end
	end

	// Stage 20: gain products
	logic signed [34:0] plin_s20, pd_s20;
	logic signed [30:0] ph_s20;
	logic stp_s20;

	always_ff @(posedge clk) begin
		if (adv[S_ERR+1]) begin
			plin_s20 <= 35'($signed({1'b0, sg_q})) * 35'(err_s19);
			pd_s20 <= 35'($signed({1'b0, dg_q})) * 35'(err_s19);
			ph_s20 <= 31'($signed({1'b0, hg_q})) * 31'(th_s19);
			stp_s20 <= stp_s19;
		end
	end

	// Stage 21: round, clamp, hold for the receiver
	logic signed [35:0] lsum;
	logic signed [36:0] asum;
	logic signed [23:0] lsh;
	logic signed [24:0] ash;
	logic signed [VEL_W-1:0] lcl, acl;
	logic signed [VEL_W-1:0] lin_s21, ang_s21;
	logic stp_s21;

	always_comb begin
		lsum = 36'(plin_s20) + 36'sd2048;
		asum = 37'(ph_s20) + 37'(pd_s20) + 37'sd2048;
		lsh = 24'(lsum >>> 12);
		ash = 25'(asum >>> 12);
		if (lsh > $signed({9'd0, maxl_q})) begin
			lcl = $signed({1'b0, maxl_q});
		end else if (lsh < -$signed({9'd0, maxl_q})) begin
			lcl = -$signed({1'b0, maxl_q});
		end else begin
			lcl = lsh[VEL_W-1:0];
		end
		if (ash > $signed({10'd0, maxa_q})) begin
			acl = $signed({1'b0, maxa_q});
		end else if (ash < -$signed({10'd0, maxa_q})) begin
			acl = -$signed({1'b0, maxa_q});
		end else begin
			acl = ash[VEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS]) begin
			lin_s21 <= stp_s20 ? '0 : lcl;
			ang_s21 <= stp_s20 ? '0 : acl;
			stp_s21 <= stp_s20;
		end
	end

	assign linear_vel = lin_s21;
	assign angular_vel = ang_s21;
	assign stopped = stp_s21;

`include "target_follow_velocity_controller_core_assert.svh"
	`TFVC_ASSERT_IMPL(a_stop_zero, out_valid && stopped, linear_vel == '0 && angular_vel == '0, "stopped item carries non-zero velocity")
	`TFVC_ASSERT_IMPL(a_full_only, !in_ready, out_valid && !out_ready, "input held off while the pipe has room")
	`TFVC_ASSERT(a_zero_depth_half_pi, !v_s[S_ERR-1] || !zz_s[L] || !xp_s[L] || ang_f == HALF_PI_Q16, "zero depth bearing is not half pi")
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
	import tfvc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [VEL_W-1:0] lin;
		logic signed [VEL_W-1:0] ang;
		logic stp;
	} vel_cmd_t;

	class follow_scoreboard;
		vel_cmd_t pending[$];
		int errors;
		longint stop_d, cam_off, k_speed, k_head, k_dist, lim_lin, lim_ang;

		function new();
			errors = 0;
			stop_d = RST_STOP_DIST;
			cam_off = RST_CAM_OFFSET;
			k_speed = RST_SPEED_GAIN;
			k_head = RST_HEAD_GAIN;
			k_dist = RST_DIST_GAIN;
			lim_lin = RST_MAX_LINEAR;
			lim_ang = RST_MAX_ANGULAR;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] v);
			case (idx)
				REG_STOP_DIST: stop_d = v;
				REG_CAM_OFFSET: cam_off = v;
				REG_SPEED_GAIN: k_speed = v;
				REG_HEAD_GAIN: k_head = v;
				REG_DIST_GAIN: k_dist = v;
				REG_MAX_LINEAR: lim_lin = v;
				REG_MAX_ANGULAR: lim_ang = v;
				default: ;
			endcase
		endfunction

		function longint fdiv(longint v, int s);
			return v >>> s;
		endfunction

		function longint root(longint v);
			longint r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - r - b;
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function longint heading(longint x, longint z);
			longint a, b, acc, na, nb;
			longint tbl[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
				256, 128, 64, 32, 16, 8, 4, 2};
			acc = 0;
			if (z == 0) begin
				if (x > 0) acc = 102944;
				else if (x < 0) acc = -102944;
				return fdiv(acc + 8, 4);
			end
			a = (z < 0 ? -z : z) * 16384;
			b = (z < 0 ? -x : x) * 16384;
			for (int i = 0; i < 16; i++) begin
				if (b >= 0) begin
					na = a + fdiv(b, i);
					nb = b - fdiv(a, i);
					acc += tbl[i];
				end else begin
					na = a - fdiv(b, i);
					nb = b + fdiv(a, i);
					acc -= tbl[i];
				end
				a = na;
				b = nb;
			end
			return fdiv(acc + 8, 4);
		endfunction

		function longint clip(longint v, longint l);
			if (v > l) return l;
			if (v < -l) return -l;
			return v;
		endfunction

		function void note_pose(logic signed [POS_W-1:0] xp, logic signed [POS_W-1:0] zp);
			longint x, z, sq, err, l, w;
			vel_cmd_t c;
			x = xp;
			z = zp;
			sq = x * x + z * z;
			c.lin = 0;
			c.ang = 0;
			c.stp = 1;
			if (sq > stop_d * stop_d) begin
				err = root(sq) - stop_d - cam_off;
				l = clip(fdiv(k_speed * err + 2048, 12), lim_lin);
				w = clip(fdiv(k_head * heading(x, z) + k_dist * err + 2048, 12), lim_ang);
				c.lin = l[15:0];
				c.ang = w[15:0];
				c.stp = 0;
			end
			pending.push_back(c);
		endfunction

		function void check_cmd(logic signed [VEL_W-1:0] l, logic signed [VEL_W-1:0] w,
				logic s);
			vel_cmd_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected item lin=%0d ang=%0d stopped=%0b", $time, l, w, s);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (l !== e.lin) begin
				$display("%0t: linear_vel expected %0d actual %0d", $time, e.lin, l);
				errors++;
			end
			if (w !== e.ang) begin
				$display("%0t: angular_vel expected %0d actual %0d", $time, e.ang, w);
				errors++;
			end
			if (s !== e.stp) begin
				$display("%0t: stopped expected %0b actual %0b", $time, e.stp, s);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, in_valid, in_ready, out_valid, out_ready, stopped;
	logic signed [POS_W-1:0] x_pos, z_pos;
	logic signed [VEL_W-1:0] linear_vel, angular_vel;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_wdata;

	follow_scoreboard sb;
	bit calm;
	int hold_off;
	longint cycles;

	target_follow_velocity_controller_core u_top (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// receiver: random stalls plus the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) sb.check_cmd(linear_vel, angular_vel, stopped);
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 12);
			end
		end
	end

	task automatic cfg_write(reg_idx_t idx, logic [REG_W-1:0] v);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		sb.set_reg(idx, v);
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	task automatic send_pose(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] z);
		while (!calm && $urandom_range(99) < 12) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		x_pos <= x;
		z_pos <= z;
		do @(posedge clk); while (!in_ready);
		sb.note_pose(x, z);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic signed [POS_W-1:0] rnd_pos();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return $signed(16'($urandom_range(8191))) - 16'sd4096;
			2: return ($urandom_range(1)) ? 16'(16'h7fff - 16'($urandom_range(3))) :
				16'(16'h8000 + 16'($urandom_range(3)));
			default: return $signed(16'($urandom_range(1023))) - 16'sd512;
		endcase
	endfunction

	task automatic random_cfg(bit extreme);
		cfg_write(REG_STOP_DIST, extreme ? ($urandom_range(1) ? 15'h7fff : 15'h0) :
			15'($urandom_range(8191)));
		cfg_write(REG_CAM_OFFSET, extreme ? 15'(15'h7fff * $urandom_range(1)) :
			15'($urandom_range(4095)));
		cfg_write(REG_SPEED_GAIN, extreme ? 15'h7fff : 15'($urandom));
		cfg_write(REG_HEAD_GAIN, extreme ? 15'(15'h7fff * $urandom_range(1)) :
			15'($urandom));
		cfg_write(REG_DIST_GAIN, extreme ? 15'h7fff : 15'($urandom));
		cfg_write(REG_MAX_LINEAR, extreme ? 15'(15'h7fff * $urandom_range(1)) :
			15'($urandom));
		cfg_write(REG_MAX_ANGULAR, extreme ? 15'h7fff : 15'($urandom));
	endtask

	initial begin
		sb = new();
		calm = 0;
		hold_off = 0;
		arst_n = 0;
		in_valid = 0;
		x_pos = 0;
		z_pos = 0;
		cfg_wr_en = 0;
		cfg_index = 0;
		cfg_wdata = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: origin, zero depth, extremes, behind, stop boundary
		send_pose(0, 0);
		send_pose(16'sd4096, 0);
		send_pose(-16'sd4096, 0);
		send_pose(16'sh7fff, 16'sh7fff);
		send_pose(16'sh8000, 16'sh8000);
		send_pose(16'sh7fff, 16'sh8000);
		send_pose(16'sh8000, 16'sh7fff);
		send_pose(0, 16'sd2048);
		send_pose(0, 16'sd2049);
		send_pose(16'sd1000, -16'sd8000);
		send_pose(-16'sd1, 16'sd12000);
		send_pose(16'sh5555, -16'sh2aaa);
		drain();
		cfg_write(REG_MAX_LINEAR, 0);
		cfg_write(REG_MAX_ANGULAR, 0);
		cfg_write(reg_idx_t'(3'd7), 15'h1234);
		send_pose(16'sd20000, 16'sd3000);
		send_pose(-16'sd20000, 0);
		drain();
		random_cfg(1);
		send_pose(16'sh7fff, 0);
		send_pose(0, 16'sh8000);
		send_pose(16'sh7fff, 16'sh7fff);
		drain();
		for (int ph = 0; ph < 9; ph++) begin
			random_cfg(ph % 4 == 3);
			calm = (ph == 2);
			if (ph == 4) hold_off = 200;
			for (int i = 0; i < 150; i++) send_pose(rnd_pos(), rnd_pos());
			drain();
		end
		if (sb.pending.size() == 0 && sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
